FILE: rtl/core/sb2ad_pkg.sv
// Shared types and constants for the signed binary to ASCII decimal unit.
package sb2ad_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned BCD_W    = DIGITS * DIGIT_W;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int unsigned STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int unsigned PTR_W         = $clog2(DIGITS);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic set_ptr;
        logic dec_ptr;
        logic show_sign;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic ptr_zero;
        logic negative;
    } stat_t;

endpackage

FILE: rtl/core/signed_binary_to_ascii_decimal_unit.sv
// Signed 32-bit integer to ASCII decimal text, one character per output request.
// After an input request is taken, double dabble converts the magnitude at 4 bits per cycle,
// then a setup state finds the lead digit before the first character is offered.
// Each number gives 1 to 11 characters (a sign for negative values, then up to 10 digits);
// the next input is taken the cycle after the last character leaves.
// Reset clears the controller and counters only; there is no clearing pass.
module signed_binary_to_ascii_decimal_unit
    import sb2ad_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CHAR_W-1:0]         char_code,
    output logic                      last_char
);

    cmd_t  cmd;
    stat_t stat;

    sb2ad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    sb2ad_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

FILE: rtl/core/sb2ad_ctrl.sv
// Controller state machine: sequences load, conversion, sign and digit output.
module sb2ad_ctrl
    import sb2ad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (stat.conv_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = stat.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (!out_stall)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (!out_stall && stat.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_SETUP:
            begin
                cmd.set_ptr = 1'b1;
            end
            ST_SIGN:
            begin
                out_valid     = 1'b1;
                cmd.show_sign = 1'b1;
            end
            ST_DIGIT:
            begin
                out_valid   = 1'b1;
                cmd.dec_ptr = !out_stall && !stat.ptr_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_accept_starts_conv: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_CONV)
    ) else $error("accepted request did not start conversion");

    a_no_accept_while_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall
    ) else $error("input taken while characters pending");

    a_conv_to_setup: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && stat.conv_done) |=> (state_reg == ST_SETUP)
    ) else $error("conversion end not followed by setup");

    a_last_char_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && !out_stall && stat.ptr_zero) |=> (state_reg == ST_IDLE)
    ) else $error("last character did not return to idle");

endmodule

FILE: rtl/core/sb2ad_datapath.sv
// Datapath: magnitude, four-bit-per-cycle double dabble and character select.
module sb2ad_datapath
    import sb2ad_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic [CHAR_W-1:0]        char_code,
    output logic                     last_char
);

    logic [VALUE_W-1:0]    mag_reg;
    logic [VALUE_W-1:0]    mag_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic                  neg_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic [PTR_W-1:0]      lead_idx;
    logic [DIGIT_W-1:0]    cur_digit;

    // one shift-and-add-3 step: fix up each digit, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble_bit(
        input logic [BCD_W-1:0] bcd_in,
        input logic             bit_in
    );
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] d;
        adj = bcd_in;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_in[i*DIGIT_W +: DIGIT_W];
            if (d >= 4'd5)
            begin
                adj[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    always_comb
    begin
        bcd_next = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            bcd_next = dabble_bit(bcd_next, mag_reg[VALUE_W-1-b]);
        end
        mag_next = {mag_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
    end

    // highest nonzero digit; zero keeps the units digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                lead_idx = PTR_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= value[VALUE_W-1] ? (~value + 1'b1) : value;
            neg_reg <= value[VALUE_W-1];
            bcd_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.set_ptr)
        begin
            ptr_next = lead_idx;
        end
        else if (cmd.dec_ptr)
        begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.conv_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign cur_digit = bcd_reg[ptr_reg*DIGIT_W +: DIGIT_W];

    assign stat.conv_done = (step_reg == STEP_CNT_W'(CONV_STEPS - 1));
    assign stat.ptr_zero  = (ptr_reg == '0);
    assign stat.negative  = neg_reg;

    assign char_code = cmd.show_sign ? CH_MINUS : (CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit});
    assign last_char = !cmd.show_sign && (ptr_reg == '0);

endmodule
